/* rtl/qsu_pkg.sv */
// Shared codes, character constants and types for the quoted string unescaper.
package qsu_pkg;

    // Decoder phase codes
    localparam logic [2:0] PH_WAIT  = 3'd0;
    localparam logic [2:0] PH_BODY  = 3'd1;
    localparam logic [2:0] PH_ESC   = 3'd2;
    localparam logic [2:0] PH_HEXHI = 3'd3;
    localparam logic [2:0] PH_HEXLO = 3'd4;

    // Result status codes
    localparam logic [2:0] ST_BYTE    = 3'd0;
    localparam logic [2:0] ST_END     = 3'd1;
    localparam logic [2:0] ST_NOQUOTE = 3'd2;
    localparam logic [2:0] ST_EOF     = 3'd3;
    localparam logic [2:0] ST_NEWLINE = 3'd4;
    localparam logic [2:0] ST_BADESC  = 3'd5;
    localparam logic [2:0] ST_BADHEX  = 3'd6;

    // Character constants
    localparam logic [7:0] CH_QUOTE  = 8'h22;
    localparam logic [7:0] CH_APOS   = 8'h27;
    localparam logic [7:0] CH_BSLASH = 8'h5C;
    localparam logic [7:0] CH_LF     = 8'h0A;
    localparam logic [7:0] CH_CR     = 8'h0D;
    localparam logic [7:0] CH_TAB    = 8'h09;
    localparam logic [7:0] CH_T      = 8'h74;
    localparam logic [7:0] CH_N      = 8'h6E;
    localparam logic [7:0] CH_R      = 8'h72;
    localparam logic [7:0] CH_X      = 8'h78;
    localparam logic [7:0] CH_0      = 8'h30;
    localparam logic [7:0] CH_9      = 8'h39;
    localparam logic [7:0] CH_LA     = 8'h61;
    localparam logic [7:0] CH_LF_HEX = 8'h66;
    localparam logic [7:0] CH_UA     = 8'h41;
    localparam logic [7:0] CH_UF     = 8'h46;

    // Outcome of decoding one item
    typedef struct packed {
        logic [2:0] phase;
        logic [3:0] nibble;
        logic       emit;
        logic [2:0] status;
        logic [7:0] data;
    } qsu_step_t;

endpackage

/* rtl/qsu_decode.sv */
// Combinational next-state and result logic for one input item.
module qsu_decode
    import qsu_pkg::*;
(
    input  logic [2:0] phase,
    input  logic [3:0] nibble,
    input  logic [7:0] char_in,
    input  logic       end_of_input,
    output qsu_step_t  step
);

    // Hex digit check: bit 4 marks a valid digit, bits 3:0 its value
    function automatic logic [4:0] hex_value(input logic [7:0] c);
        logic [7:0] diff;
        begin
            diff = 8'd0;
            if (c >= CH_0 && c <= CH_9)
            begin
                diff = c - CH_0;
                hex_value = {1'b1, diff[3:0]};
            end
            else if (c >= CH_LA && c <= CH_LF_HEX)
            begin
                diff = c - CH_LA + 8'd10;
                hex_value = {1'b1, diff[3:0]};
            end
            else if (c >= CH_UA && c <= CH_UF)
            begin
                diff = c - CH_UA + 8'd10;
                hex_value = {1'b1, diff[3:0]};
            end
            else
            begin
                hex_value = 5'd0;
            end
        end
    endfunction

    logic [4:0] hex;

    assign hex = hex_value(char_in);

    // Decode the item against the current phase
    always_comb
    begin
        step.phase  = phase;
        step.nibble = nibble;
        step.emit   = 1'b0;
        step.status = ST_BYTE;
        step.data   = 8'd0;
        unique case (phase)
            PH_BODY:
            begin
                if (end_of_input)
                begin
                    step.phase = PH_WAIT; step.nibble = 4'd0;
                    step.emit = 1'b1; step.status = ST_EOF;
                end
                else if (char_in == CH_QUOTE)
                begin
                    step.phase = PH_WAIT;
                    step.emit = 1'b1; step.status = ST_END;
                end
                else if (char_in == CH_LF)
                begin
                    step.phase = PH_WAIT; step.nibble = 4'd0;
                    step.emit = 1'b1; step.status = ST_NEWLINE;
                end
                else if (char_in == CH_BSLASH)
                begin
                    step.phase = PH_ESC;
                end
                else
                begin
                    step.emit = 1'b1; step.data = char_in;
                end
            end
            PH_ESC:
            begin
                step.phase = PH_BODY;
                step.emit  = 1'b1;
                if (end_of_input)
                begin
                    step.phase = PH_WAIT; step.nibble = 4'd0; step.status = ST_BADESC;
                end
                else if (char_in == CH_T)
                    step.data = CH_TAB;
                else if (char_in == CH_N)
                    step.data = CH_LF;
                else if (char_in == CH_R)
                    step.data = CH_CR;
                else if (char_in == CH_QUOTE || char_in == CH_APOS || char_in == CH_BSLASH)
                    step.data = char_in;
                else if (char_in == CH_X)
                begin
                    step.phase = PH_HEXHI; step.emit = 1'b0;
                end
                else
                begin
                    step.phase = PH_WAIT; step.nibble = 4'd0; step.status = ST_BADESC;
                end
            end
            PH_HEXHI:
            begin
                if (end_of_input || !hex[4])
                begin
                    step.phase = PH_WAIT; step.nibble = 4'd0;
                    step.emit = 1'b1; step.status = ST_BADHEX;
                end
                else
                begin
                    step.phase = PH_HEXLO; step.nibble = hex[3:0];
                end
            end
            PH_HEXLO:
            begin
                step.emit   = 1'b1;
                step.nibble = 4'd0;
                if (end_of_input || !hex[4])
                begin
                    step.phase = PH_WAIT; step.status = ST_BADHEX;
                end
                else
                begin
                    step.phase = PH_BODY; step.data = {nibble, hex[3:0]};
                end
            end
            default:
            begin
                // Waiting for the opening quote; unused codes land here too
                if (!end_of_input && char_in == CH_QUOTE)
                begin
                    step.phase = PH_BODY;
                end
                else
                begin
                    step.phase = PH_WAIT; step.nibble = 4'd0;
                    step.emit = 1'b1; step.status = ST_NOQUOTE;
                end
            end
        endcase
    end

endmodule

/* rtl/quoted_string_unescaper.sv */
// Each accepted item waits in the input register; its result, if any, goes to the result register.
// Throughput: one item per cycle; the input register and the result register
// each advance whenever the stage after them is free or being emptied.
// An item that yields no result leaves the result register empty for that cycle.
// Reset (rst_n low, asynchronous): both stages empty, decoder waits for a quote.
module quoted_string_unescaper
    import qsu_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       s_axis_tvalid,
    output logic       s_axis_tready,
    input  logic [7:0] s_axis_tdata,   // [7:0] char_in
    input  logic       s_axis_tuser,   // [0] end_of_input
    output logic       m_axis_tvalid,
    input  logic       m_axis_tready,
    output logic [7:0] m_axis_tdata,   // [7:0] byte_out
    output logic [2:0] m_axis_tuser    // [2:0] status
);

    logic       in_valid_reg;
    logic [7:0] in_char_reg;
    logic       in_eoi_reg;
    logic [2:0] phase_reg;
    logic [2:0] phase_next;
    logic [3:0] nibble_reg;
    logic [3:0] nibble_next;
    logic       out_valid_reg;
    logic       out_valid_next;
    logic [2:0] out_status_reg;
    logic [7:0] out_byte_reg;
    logic       out_free;
    logic       advance;
    qsu_step_t  step;

    qsu_decode u_decode (
        .phase        (phase_reg),
        .nibble       (nibble_reg),
        .char_in      (in_char_reg),
        .end_of_input (in_eoi_reg),
        .step         (step)
    );

    // Stage handshakes
    assign out_free      = !out_valid_reg || m_axis_tready;
    assign advance       = in_valid_reg && out_free;
    assign s_axis_tready = !in_valid_reg || out_free;

    // Decoder state moves only when the registered item is consumed
    always_comb
    begin
        phase_next     = phase_reg;
        nibble_next    = nibble_reg;
        out_valid_next = out_valid_reg && !m_axis_tready;
        if (advance)
        begin
            phase_next     = step.phase;
            nibble_next    = step.nibble;
            out_valid_next = step.emit;
        end
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            phase_reg     <= PH_WAIT;
            nibble_reg    <= 4'd0;
        end
        else
        begin
            if (s_axis_tready)
                in_valid_reg <= s_axis_tvalid;
            out_valid_reg <= out_valid_next;
            phase_reg     <= phase_next;
            nibble_reg    <= nibble_next;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        if (s_axis_tready && s_axis_tvalid)
        begin
            in_char_reg <= s_axis_tdata;
            in_eoi_reg  <= s_axis_tuser;
        end
        if (advance && step.emit)
        begin
            out_status_reg <= step.status;
            out_byte_reg   <= step.data;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_byte_reg;
    assign m_axis_tuser  = out_status_reg;

endmodule

/* sim/tb_quoted_string_unescaper.sv */
// Self-checking testbench for the quoted string unescaper: directed table, then random strings.
module tb_quoted_string_unescaper
    import qsu_pkg::*;
();

    localparam int IDLE_LIMIT   = 3000;  // cycles with no item moving on either side
    localparam int HOLD_CYCLES  = 80;    // long receiver hold-off
    localparam int HOLD_AFTER   = 150;   // input items accepted before the hold-off
    localparam int RANDOM_ITEMS = 520;
    localparam int MAX_PRINTS   = 100;

    // Characters used only here
    localparam logic [7:0] CH_Q_LOWER = 8'h71;

    typedef enum logic [1:0] {
        CHK_MODEL,  // result, if any, comes from the decoder model
        CHK_NONE,   // item yields no result
        CHK_GIVEN   // result typed into the table
    } chk_kind_t;

    typedef struct {
        logic [7:0] chr;
        logic       eoi;
        chk_kind_t  chk;
        logic [2:0] st;
        logic [7:0] byt;
    } char_item_t;

    typedef struct {
        logic [2:0] st;
        logic [7:0] byt;
    } byte_result_t;

    logic       clk;
    logic       rst_n;
    logic       s_axis_tvalid;
    logic       s_axis_tready;
    logic [7:0] s_axis_tdata;   // [7:0] char_in
    logic       s_axis_tuser;   // [0] end_of_input
    logic       m_axis_tvalid;
    logic       m_axis_tready;
    logic [7:0] m_axis_tdata;   // [7:0] byte_out
    logic [2:0] m_axis_tuser;   // [2:0] status

    char_item_t   stim_q[$];
    byte_result_t pending_results[$];
    char_item_t   dir_table [0:28];

    logic [2:0] dec_phase;
    logic [3:0] dec_nibble;
    int         in_count;
    int         err_count;
    int         idle_cycles;
    bit         stim_done;

    quoted_string_unescaper DUT (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    // Drive the clock
    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    task automatic flag_error(input string msg);
        if (err_count < MAX_PRINTS)
            $display("ERROR @%0t: %s", $time, msg);
        err_count++;
    endtask

    function automatic int hex_value(input logic [7:0] c);
        if (c >= CH_0 && c <= CH_9)
            return int'(c - CH_0);
        if (c >= CH_LA && c <= CH_LF_HEX)
            return int'(c - CH_LA) + 10;
        if (c >= CH_UA && c <= CH_UF)
            return int'(c - CH_UA) + 10;
        return -1;
    endfunction

    // Abort the current string: back to waiting for a quote
    function automatic bit fail_string(input logic [2:0] st, output byte_result_t res);
        dec_phase  = PH_WAIT;
        dec_nibble = 4'h0;
        res.st     = st;
        res.byt    = 8'h00;
        return 1'b1;
    endfunction

    // Decode one item; return 1 when it yields a result
    function automatic bit decode_char(input logic [7:0] c, input logic eoi,
                                       output byte_result_t res);
        int d;
        res.st  = ST_BYTE;
        res.byt = 8'h00;
        d = eoi ? -1 : hex_value(c);
        case (dec_phase)
            PH_BODY:
            begin
                if (eoi)
                    return fail_string(ST_EOF, res);
                if (c == CH_QUOTE)
                begin
                    dec_phase = PH_WAIT;
                    res.st    = ST_END;
                    return 1'b1;
                end
                if (c == CH_LF)
                    return fail_string(ST_NEWLINE, res);
                if (c == CH_BSLASH)
                begin
                    dec_phase = PH_ESC;
                    return 1'b0;
                end
                res.byt = c;
                return 1'b1;
            end
            PH_ESC:
            begin
                if (eoi)
                    return fail_string(ST_BADESC, res);
                dec_phase = PH_BODY;
                case (c)
                    CH_T:      res.byt = CH_TAB;
                    CH_N:      res.byt = CH_LF;
                    CH_R:      res.byt = CH_CR;
                    CH_QUOTE, CH_APOS, CH_BSLASH: res.byt = c;
                    CH_X:
                    begin
                        dec_phase = PH_HEXHI;
                        return 1'b0;
                    end
                    default:   return fail_string(ST_BADESC, res);
                endcase
                return 1'b1;
            end
            PH_HEXHI:
            begin
                if (d < 0)
                    return fail_string(ST_BADHEX, res);
                dec_nibble = d[3:0];
                dec_phase  = PH_HEXLO;
                return 1'b0;
            end
            PH_HEXLO:
            begin
                if (d < 0)
                    return fail_string(ST_BADHEX, res);
                res.byt    = {dec_nibble, d[3:0]};
                dec_nibble = 4'h0;
                dec_phase  = PH_BODY;
                return 1'b1;
            end
            default:
            begin
                // unused phase codes behave as waiting for a quote
                if (!eoi && c == CH_QUOTE)
                begin
                    dec_phase = PH_BODY;
                    return 1'b0;
                end
                return fail_string(ST_NOQUOTE, res);
            end
        endcase
    endfunction

    task automatic add_char(input logic [7:0] c, input logic eoi);
        char_item_t it;
        it.chr = c;
        it.eoi = eoi;
        it.chk = CHK_MODEL;
        it.st  = ST_BYTE;
        it.byt = 8'h00;
        stim_q.insert(stim_q.size(), it);
    endtask

    function automatic logic [7:0] hex_char(input int v, input bit upper);
        if (v < 10)
            return CH_0 + 8'(v);
        return (upper ? CH_UA : CH_LA) + 8'(v - 10);
    endfunction

    // Queue one random string: mostly well formed, some broken, some noise
    task automatic add_random_string();
        logic [7:0] esc_codes [0:5];
        logic [7:0] c;
        int         pick;
        int         n;
        esc_codes = '{CH_T, CH_N, CH_R, CH_QUOTE, CH_APOS, CH_BSLASH};
        pick = $urandom_range(0, 99);
        if (pick < 12)
        begin
            // noise outside any string
            repeat ($urandom_range(1, 3))
                add_char(8'($urandom_range(0, 255)), $urandom_range(0, 3) == 0);
            return;
        end
        add_char(CH_QUOTE, 1'b0);
        n = $urandom_range(0, 10);
        repeat (n)
        begin
            pick = $urandom_range(0, 9);
            if (pick < 5)
            begin
                c = 8'($urandom_range(0, 255));
                if (c == CH_QUOTE || c == CH_BSLASH || c == CH_LF)
                    c = c ^ 8'h01;
                add_char(c, 1'b0);
            end
            else if (pick < 8)
            begin
                add_char(CH_BSLASH, 1'b0);
                add_char(esc_codes[$urandom_range(0, 5)], 1'b0);
            end
            else
            begin
                add_char(CH_BSLASH, 1'b0);
                add_char(CH_X, 1'b0);
                add_char(hex_char($urandom_range(0, 15), 1'($urandom_range(0, 1))), 1'b0);
                add_char(hex_char($urandom_range(0, 15), 1'($urandom_range(0, 1))), 1'b0);
            end
        end
        // close the string, or break it
        pick = $urandom_range(0, 99);
        if (pick < 70)
            add_char(CH_QUOTE, 1'b0);
        else if (pick < 76)
            add_char(8'($urandom_range(0, 255)), 1'b1);
        else if (pick < 81)
            add_char(CH_LF, 1'b0);
        else if (pick < 87)
        begin
            add_char(CH_BSLASH, 1'b0);
            if ($urandom_range(0, 3) == 0)
                add_char(8'($urandom_range(0, 255)), 1'b1);
            else
            begin
                do
                    c = 8'($urandom_range(0, 255));
                while (c == CH_T || c == CH_N || c == CH_R || c == CH_QUOTE ||
                       c == CH_APOS || c == CH_BSLASH || c == CH_X);
                add_char(c, 1'b0);
            end
        end
        else if (pick < 95)
        begin
            add_char(CH_BSLASH, 1'b0);
            add_char(CH_X, 1'b0);
            if ($urandom_range(0, 1) == 1)
                add_char(hex_char($urandom_range(0, 15), 1'($urandom_range(0, 1))), 1'b0);
            if ($urandom_range(0, 3) == 0)
                add_char(8'($urandom_range(0, 255)), 1'b1);
            else
            begin
                do
                    c = 8'($urandom_range(0, 255));
                while (hex_value(c) >= 0);
                add_char(c, 1'b0);
            end
        end
        // otherwise leave the string open into the next one
    endtask

    // Build stimulus, reset, then wait for the end of the run
    initial
    begin
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = 8'h00;
        s_axis_tuser  = 1'b0;
        m_axis_tready = 1'b0;
        rst_n         = 1'b0;
        in_count      = 0;
        err_count     = 0;
        stim_done     = 1'b0;
        dec_phase     = PH_WAIT;
        dec_nibble    = 4'h0;

        dir_table = '{
            '{CH_UA,      1'b0, CHK_GIVEN, ST_NOQUOTE, 8'h00},  // no opening quote
            '{8'h00,      1'b1, CHK_GIVEN, ST_NOQUOTE, 8'h00},  // end of input while waiting
            '{CH_QUOTE,   1'b0, CHK_NONE,  ST_BYTE,    8'h00},
            '{8'h00,      1'b0, CHK_GIVEN, ST_BYTE,    8'h00},
            '{8'hFF,      1'b0, CHK_GIVEN, ST_BYTE,    8'hFF},
            '{CH_BSLASH,  1'b0, CHK_NONE,  ST_BYTE,    8'h00},
            '{CH_T,       1'b0, CHK_MODEL, ST_BYTE,    8'h00},
            '{CH_BSLASH,  1'b0, CHK_NONE,  ST_BYTE,    8'h00},
            '{CH_APOS,    1'b0, CHK_MODEL, ST_BYTE,    8'h00},
            '{CH_BSLASH,  1'b0, CHK_NONE,  ST_BYTE,    8'h00},
            '{CH_X,       1'b0, CHK_NONE,  ST_BYTE,    8'h00},
            '{CH_UA,      1'b0, CHK_NONE,  ST_BYTE,    8'h00},
            '{CH_9,       1'b0, CHK_MODEL, ST_BYTE,    8'h00},
            '{CH_QUOTE,   1'b0, CHK_GIVEN, ST_END,     8'h00},
            '{CH_QUOTE,   1'b0, CHK_NONE,  ST_BYTE,    8'h00},
            '{CH_BSLASH,  1'b0, CHK_NONE,  ST_BYTE,    8'h00},
            '{CH_Q_LOWER, 1'b0, CHK_GIVEN, ST_BADESC,  8'h00},  // unknown escape
            '{CH_QUOTE,   1'b0, CHK_NONE,  ST_BYTE,    8'h00},
            '{CH_BSLASH,  1'b0, CHK_NONE,  ST_BYTE,    8'h00},
            '{8'hFF,      1'b1, CHK_GIVEN, ST_BADESC,  8'h00},  // end of input after backslash
            '{CH_QUOTE,   1'b0, CHK_NONE,  ST_BYTE,    8'h00},
            '{CH_BSLASH,  1'b0, CHK_NONE,  ST_BYTE,    8'h00},
            '{CH_X,       1'b0, CHK_NONE,  ST_BYTE,    8'h00},
            '{CH_LF_HEX,  1'b0, CHK_NONE,  ST_BYTE,    8'h00},
            '{8'h00,      1'b1, CHK_GIVEN, ST_BADHEX,  8'h00},  // end of input in hex digits
            '{CH_QUOTE,   1'b0, CHK_NONE,  ST_BYTE,    8'h00},
            '{CH_LF,      1'b0, CHK_GIVEN, ST_NEWLINE, 8'h00},  // raw newline
            '{CH_QUOTE,   1'b0, CHK_NONE,  ST_BYTE,    8'h00},
            '{CH_QUOTE,   1'b1, CHK_GIVEN, ST_EOF,     8'h00}   // end of input in contents
        };
        foreach (dir_table[i])
            stim_q.insert(stim_q.size(), dir_table[i]);
        while (stim_q.size() < $size(dir_table) + RANDOM_ITEMS)
            add_random_string();

        repeat (11) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        while (!(stim_done && pending_results.size() == 0))
            @(posedge clk);
        // let any stray result show up
        repeat (6) @(posedge clk);
        if (err_count == 0)
            $display("PASS quoted_string_unescaper");
        else
            $display("FAIL quoted_string_unescaper");
        $finish;
    end

    // Offer items in bursts with random gaps
    initial
    begin : sender
        int burst_left;
        int gap;
        burst_left = 0;
        wait (rst_n === 1'b1);
        @(negedge clk);
        for (int i = 0; i < stim_q.size(); i++)
        begin
            if (burst_left == 0)
            begin
                burst_left = $urandom_range(1, 40);
                gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
                if (gap > 0)
                begin
                    s_axis_tvalid <= 1'b0;
                    repeat (gap) @(negedge clk);
                end
            end
            burst_left--;
            s_axis_tvalid <= 1'b1;
            s_axis_tdata  <= stim_q[i].chr;
            s_axis_tuser  <= stim_q[i].eoi;
            do
                @(posedge clk);
            while (!s_axis_tready);
            @(negedge clk);
        end
        s_axis_tvalid <= 1'b0;
        stim_done = 1'b1;
    end

    // Stall the output on changing patterns, with one long hold-off
    initial
    begin : receiver
        int mode;
        int mode_left;
        bit held_off;
        mode      = 0;
        mode_left = 0;
        held_off  = 1'b0;
        wait (rst_n === 1'b1);
        forever
        begin
            @(negedge clk);
            if (!held_off && in_count >= HOLD_AFTER)
            begin
                held_off = 1'b1;
                m_axis_tready <= 1'b0;
                repeat (HOLD_CYCLES) @(negedge clk);
            end
            if (mode_left == 0)
            begin
                mode      = $urandom_range(0, 3);
                mode_left = $urandom_range(8, 60);
            end
            mode_left--;
            case (mode)
                0:       m_axis_tready <= 1'b1;
                1:       m_axis_tready <= 1'($urandom_range(0, 1));
                2:       m_axis_tready <= (mode_left % 3 != 0);
                default: m_axis_tready <= ($urandom_range(0, 4) == 0);
            endcase
        end
    end

    // Predict results for each accepted input item
    always @(posedge clk)
    begin : track_inputs
        byte_result_t res;
        bit           has_res;
        if (rst_n && s_axis_tvalid && s_axis_tready)
        begin
            has_res = decode_char(s_axis_tdata, s_axis_tuser, res);
            case (stim_q[in_count].chk)
                CHK_MODEL:
                begin
                    if (has_res)
                        pending_results.insert(pending_results.size(), res);
                end
                CHK_GIVEN:
                begin
                    res.st  = stim_q[in_count].st;
                    res.byt = stim_q[in_count].byt;
                    pending_results.insert(pending_results.size(), res);
                end
                default: ;
            endcase
            in_count++;
        end
    end

    // Compare each accepted result with the oldest prediction
    always @(posedge clk)
    begin : check_results
        byte_result_t want;
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            if (pending_results.size() == 0)
                flag_error($sformatf("unexpected result status %0d byte %02h",
                                     m_axis_tuser, m_axis_tdata));
            else
            begin
                want = pending_results.pop_front();
                if (m_axis_tuser !== want.st)
                    flag_error($sformatf("status %0d, predicted %0d", m_axis_tuser, want.st));
                if (m_axis_tdata !== want.byt)
                    flag_error($sformatf("byte %02h, predicted %02h", m_axis_tdata, want.byt));
            end
        end
    end

    // End the run if nothing moves for too long
    always @(posedge clk)
    begin
        if (!rst_n || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
            idle_cycles <= 0;
        else
        begin
            idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= IDLE_LIMIT)
            begin
                $display("FAIL quoted_string_unescaper");
                $finish;
            end
        end
    end

endmodule
